// ----- hdl/hst_pkg.sv -----
`default_nettype none

package hst_pkg;

  // Slots below this index are reserved and never handed out
  localparam int FIRST_SLOT = 2;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_ZERO  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_POST
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/handle_slot_table.sv -----
// Handle slot table: TABLE_SLOTS slots of 32-bit values, slots 0 and 1 reserved.
// Input channel (in_valid/in_ready) carries one command word: opcode (insert,
// find, remove), slot_key and entry_value. Output channel (out_valid/out_ready)
// returns one word per command: status, result_key, result_value, free_slots.
// One command is worked at a time; in_ready is high only while idle.
// Find, remove and every rejected command pass through the read or post state
// before out_valid rises (the value memory read is registered); in_ready returns
// on that same edge, so no new command is taken before the result is loaded.
// Insert walks the occupancy bits one slot per cycle from slot
// TABLE_SLOTS - free count, wrapping to slot 2, and probes 1 to TABLE_SLOTS - 2
// slots; out_valid rises and in_ready returns on the edge that commits the
// insert or, if no slot is free, when the post state loads the result.
// Reset clears all occupancy bits at once (table empty) and sets the free
// count to TABLE_SLOTS - 2; no clearing pass is needed.
// The result sits in an output register; if the receiver stalls, a finished
// command waits in its last state and commits only once the register frees,
// and no new command is taken until then.
`default_nettype none

module handle_slot_table #(
  parameter int TABLE_SLOTS = 128
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  slot_key,
  input  wire logic [31:0] entry_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [7:0]       result_key,
  output logic [31:0]      result_value,
  output logic [7:0]       free_slots
);

  import hst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int MAX_OPEN = TABLE_SLOTS - FIRST_SLOT;
  localparam logic [7:0] SLOTS_K = 8'(TABLE_SLOTS);
  localparam logic [7:0] MAX_OPEN_K = 8'(MAX_OPEN);
  localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(FIRST_SLOT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_OPEN - 1);

  state_t state, state_next;

  logic [TABLE_SLOTS-1:0] valid;
  logic [31:0]            mem [TABLE_SLOTS];
  logic [31:0]            rd_data;
  logic [7:0]             count, count_next;
  logic [IDX_W-1:0]       pos, pos_next;
  logic [IDX_W-1:0]       scan_n, scan_n_next;
  logic [1:0]             w_status, w_status_next;
  logic [7:0]             w_key;
  logic [31:0]            w_val;
  logic                   w_remove;

  logic                   accept, out_free, load_out, mem_we, mem_re;
  logic                   valid_set, valid_clr;
  logic [IDX_W-1:0]       rd_idx;
  logic [1:0]             o_status;
  logic [7:0]             o_key;
  logic [31:0]            o_value;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rd_idx   = w_key[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    scan_n_next   = scan_n;
    w_status_next = w_status;
    load_out      = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    valid_set     = 1'b0;
    valid_clr     = 1'b0;
    o_status      = w_status;
    o_key         = w_key;
    o_value       = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (opcode)
            OP_INSERT: begin
              if (entry_value == '0) begin
                state_next    = ST_POST;
                w_status_next = STAT_ZERO;
              end else if (count == '0 || count > MAX_OPEN_K) begin
                state_next    = ST_POST;
                w_status_next = STAT_FULL;
              end else begin
                state_next  = ST_SCAN;
                pos_next    = IDX_W'(SLOTS_K - count);
                scan_n_next = '0;
              end
            end
            OP_FIND, OP_REMOVE: begin
              if (slot_key >= SLOTS_K) begin
                state_next    = ST_POST;
                w_status_next = STAT_EMPTY;
              end else begin
                state_next = ST_READ;
                mem_re     = 1'b1;
              end
            end
            default: begin
              state_next    = ST_POST;
              w_status_next = STAT_EMPTY;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!valid[pos]) begin
          if (out_free) begin
            mem_we     = 1'b1;
            valid_set  = 1'b1;
            count_next = count - 8'd1;
            load_out   = 1'b1;
            o_status   = STAT_OK;
            o_key      = 8'(pos);
            state_next = ST_IDLE;
          end
        end else if (scan_n == LAST_STEP) begin
          // probed every allocatable slot without a hit
          state_next    = ST_POST;
          w_status_next = STAT_FULL;
        end else begin
          pos_next    = (pos == LAST_IDX) ? FIRST_IDX : pos + 1'b1;
          scan_n_next = scan_n + 1'b1;
        end
      end
      ST_READ: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          if (valid[rd_idx]) begin
            o_status = STAT_OK;
            o_value  = rd_data;
            if (w_remove) begin
              valid_clr  = 1'b1;
              count_next = count + 8'd1;
            end
          end else begin
            o_status = STAT_EMPTY;
          end
        end
      end
      ST_POST: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // occupancy bits and free count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= MAX_OPEN_K;
    end else begin
      count <= count_next;
      if (valid_set) begin
        valid[pos] <= 1'b1;
      end
      if (valid_clr) begin
        valid[rd_idx] <= 1'b0;
      end
    end
  end

  // value store; unoccupied entries are masked by the occupancy bits
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[pos] <= w_val;
    end
    if (mem_re) begin
      rd_data <= mem[slot_key[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    scan_n   <= scan_n_next;
    w_status <= w_status_next;
    if (accept) begin
      w_key    <= slot_key;
      w_val    <= entry_value;
      w_remove <= (opcode == OP_REMOVE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status       <= o_status;
      result_key   <= o_key;
      result_value <= o_value;
      free_slots   <= count_next;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_OPEN_K)
    else $error("free count above allocatable slots");

  a_count_match: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) + int'(count) == MAX_OPEN)
    else $error("free count disagrees with occupancy bits");

  a_reserved: assert property (@(posedge clk) disable iff (rst)
    !valid[0] && !valid[1])
    else $error("reserved slot marked occupied");

  a_scan_pos: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> pos >= FIRST_IDX && pos <= LAST_IDX)
    else $error("scan position outside allocatable slots");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result overwrote an untaken word");

endmodule

`default_nettype wire

// ----- sim/handle_slot_table_tb.sv -----
`timescale 1ns / 100ps

module handle_slot_table_tb;
  import hst_pkg::*;

  localparam int SLOTS = 128;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  key;
    logic [31:0] value;
    logic [7:0]  free;
  } handle_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_INSERT;
  logic [7:0]  slot_key = 8'd0;
  logic [31:0] entry_value = 32'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [7:0]  result_key;
  logic [31:0] result_value;
  logic [7:0]  free_slots;

  // shadow of the table as seen by the predictor
  logic [31:0] slot_store [SLOTS];
  logic [7:0]  free_count;

  handle_reply_t pending_replies[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  handle_slot_table #(.TABLE_SLOTS(SLOTS)) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .slot_key(slot_key),
    .entry_value(entry_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .result_key(result_key),
    .result_value(result_value),
    .free_slots(free_slots)
  );

  always #2 clk = ~clk;

  function automatic handle_reply_t apply_handle_op(logic [1:0] op, logic [7:0] key,
                                                    logic [31:0] val);
    handle_reply_t r;
    int pos;
    bit placed;
    r.status = STAT_EMPTY;
    r.key = key;
    r.value = 32'd0;
    placed = 1'b0;
    if (op == OP_INSERT) begin
      if (val == 32'd0) begin
        r.status = STAT_ZERO;
      end else if (free_count == 8'd0 || free_count > SLOTS - FIRST_SLOT) begin
        r.status = STAT_FULL;
      end else begin
        r.status = STAT_FULL;
        pos = SLOTS - free_count;
        for (int n = 0; n < SLOTS - FIRST_SLOT && !placed; n++) begin
          if (slot_store[pos] == 32'd0) begin
            slot_store[pos] = val;
            free_count = free_count - 8'd1;
            r.status = STAT_OK;
            r.key = pos[7:0];
            placed = 1'b1;
          end else begin
            pos++;
            if (pos >= SLOTS) pos = FIRST_SLOT;
          end
        end
      end
    end else if (op == OP_FIND || op == OP_REMOVE) begin
      if (key < SLOTS && slot_store[key] != 32'd0) begin
        r.value = slot_store[key];
        r.status = STAT_OK;
        if (op == OP_REMOVE) begin
          slot_store[key] = 32'd0;
          free_count = free_count + 8'd1;
        end
      end
    end
    r.free = free_count;
    return r;
  endfunction

  // random occupied slot, or any key when the table is empty
  function automatic logic [7:0] pick_live_key();
    int start;
    int idx;
    start = $urandom_range(SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      idx = (start + i) % SLOTS;
      if (slot_store[idx] != 32'd0) return idx[7:0];
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 32'd0;
    if (r < 6) return 32'hFFFF_FFFF;
    if (r < 8) return 32'd1;
    return $urandom;
  endfunction

  function automatic logic [7:0] pick_any_key();
    int r;
    r = $urandom_range(9);
    case (r)
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'(SLOTS - 1);
      3: return 8'(SLOTS);
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_word(logic [1:0] op, logic [7:0] key, logic [31:0] val);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
      @(negedge clk);
    end
    in_valid = 1'b1;
    opcode = op;
    slot_key = key;
    entry_value = val;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(apply_handle_op(op, key, val));
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_random_word(int insert_pct);
    int r;
    r = $urandom_range(99);
    if (r < insert_pct)
      send_word(OP_INSERT, 8'($urandom_range(255)), pick_value());
    else if (r < insert_pct + (95 - insert_pct) / 2)
      send_word(OP_REMOVE, ($urandom_range(4) != 0) ? pick_live_key() : pick_any_key(),
                $urandom);
    else if (r < 95)
      send_word(OP_FIND, ($urandom_range(4) != 0) ? pick_live_key() : pick_any_key(),
                $urandom);
    else
      send_word(OP_UNUSED, 8'($urandom_range(255)), $urandom);
  endtask

  task automatic test_directed();
    logic [7:0] k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_word(OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 8'h00, 32'd0);
    send_word(OP_INSERT, 8'h00, 32'd1);
    send_word(OP_INSERT, 8'h5A, 32'h8000_0000);
    send_word(OP_FIND, 8'd0, 32'd0);
    send_word(OP_FIND, 8'd1, 32'hFFFF_FFFF);
    send_word(OP_FIND, 8'd2, 32'd0);
    send_word(OP_FIND, 8'(SLOTS - 1), 32'd0);
    send_word(OP_FIND, 8'(SLOTS), 32'd0);
    send_word(OP_FIND, 8'hFF, 32'd0);
    send_word(OP_REMOVE, 8'd2, 32'd0);
    send_word(OP_REMOVE, 8'd2, 32'd0);
    send_word(OP_REMOVE, 8'd1, 32'd0);
    send_word(OP_REMOVE, 8'hFF, 32'd0);
    send_word(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 8'h00, 32'd0);
    send_word(OP_INSERT, 8'h00, 32'h1234_5678);
    k = pick_live_key();
    send_word(OP_FIND, k, 32'd0);
    send_word(OP_REMOVE, k, 32'd0);
    release_input();
  endtask

  // fill the table, hit the full and zero cases, force the scan to wrap, drain
  task automatic test_fill_and_wrap();
    while (free_count != 8'd0)
      send_word(OP_INSERT, 8'($urandom_range(255)), $urandom | 32'd1);
    send_word(OP_INSERT, 8'd0, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 8'd0, 32'd0);
    send_word(OP_FIND, 8'(SLOTS - 1), 32'd0);
    send_word(OP_REMOVE, 8'd5, 32'd0);
    send_word(OP_INSERT, 8'd0, 32'hCAFE_0005);
    send_word(OP_REMOVE, 8'd3, 32'd0);
    send_word(OP_REMOVE, 8'(SLOTS - 2), 32'd0);
    send_word(OP_INSERT, 8'd0, 32'hCAFE_0001);
    send_word(OP_INSERT, 8'd0, 32'hCAFE_0002);
    send_word(OP_INSERT, 8'd0, 32'hCAFE_0003);
    for (int i = SLOTS - 1; i >= FIRST_SLOT; i--) send_word(OP_REMOVE, i[7:0], 32'd0);
    send_word(OP_FIND, 8'd2, 32'd0);
    release_input();
  endtask

  task automatic test_random_traffic(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) send_random_word(((i / 100) % 2 == 0) ? 60 : 25);
    release_input();
  endtask

  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 400;
    for (int i = 0; i < 24; i++) send_random_word(40);
    release_input();
  endtask

  // receiver: random stalls, or one long hold-off on request
  always begin
    @(negedge clk);
    if (hold_cycles != 0) begin
      out_ready = 1'b0;
      repeat (hold_cycles) @(negedge clk);
      hold_cycles = 0;
    end
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    handle_reply_t got;
    handle_reply_t want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, result_key, result_value, free_slots};
      if (pending_replies.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word status %0d key %0d value %h free %0d",
                 $time, got.status, got.key, got.value, got.free);
      end else begin
        want = pending_replies.pop_front();
        if (got != want) begin
          error_count++;
          $display("%0t: mismatch exp status %0d key %0d value %h free %0d,",
                   $time, want.status, want.key, want.value, want.free,
                   " got status %0d key %0d value %h free %0d",
                   got.status, got.key, got.value, got.free);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) slot_store[i] = 32'd0;
    free_count = 8'(SLOTS - FIRST_SLOT);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_fill_and_wrap();
    test_random_traffic(0, 0, 400);
    test_random_traffic(54, 0, 400);
    test_random_traffic(0, 54, 400);
    test_random_traffic(26, 26, 400);
    test_output_hold();

    while (pending_replies.size() != 0) @(posedge clk);
    // the worst insert scan walks one slot per cycle across the table
    repeat (SLOTS + 20) @(posedge clk);
    if (error_count == 0 && pending_replies.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
